// ----- design/hslrgb_pkg.sv -----
// Types, constants and helpers for the HSL to RGB converter.
package hslrgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int FIELD_W   = 13;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int SIX_W     = FRAC_BITS + 3;
  localparam int SUM_W     = FRAC_BITS + 2;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int TDATA_W   = ((4 * FIELD_W + 7) / 8) * 8;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int THIRD     = ONE / 3;

  localparam logic [VAL_W-1:0]  ONE_V   = VAL_W'(ONE);
  localparam logic [VAL_W-1:0]  THIRD_V = VAL_W'(THIRD);
  localparam logic [PROD_W-1:0] HALF_P  = PROD_W'(ONE / 2);
  localparam logic [SIX_W-1:0]  ONE_X   = SIX_W'(ONE);
  localparam logic [SIX_W-1:0]  THREE_X = SIX_W'(3 * ONE);
  localparam logic [SIX_W-1:0]  FOUR_X  = SIX_W'(4 * ONE);

  // Segment of the hue ramp a channel falls on
  typedef enum logic [1:0] {
    RG_RISE,
    RG_TOP,
    RG_FALL,
    RG_BOT
  } region_e;

  typedef struct packed {
    region_e          rgn;
    logic [VAL_W-1:0] fac;
  } ramp_sel_t;

  function automatic logic [VAL_W-1:0] sat_one(input logic [FIELD_W-1:0] x);
    logic [VAL_W-1:0] r;
    if (VAL_W'(x) > ONE_V || (FIELD_W > VAL_W && (x >> VAL_W) != '0)) r = ONE_V;
    else r = VAL_W'(x);
    return r;
  endfunction

  // Pick the ramp segment and the multiplier for a wrapped hue sample t in 0..ONE
  function automatic ramp_sel_t ramp_select(input logic [VAL_W-1:0] t);
    logic [SIX_W-1:0] six_t;
    ramp_sel_t        r;
    six_t = (SIX_W'(t) << 2) + (SIX_W'(t) << 1);
    r.fac = '0;
    if (six_t < ONE_X) begin
      r.rgn = RG_RISE;
      r.fac = VAL_W'(six_t);
    end else if (six_t < THREE_X) begin
      r.rgn = RG_TOP;
    end else if (six_t < FOUR_X) begin
      r.rgn = RG_FALL;
      r.fac = VAL_W'(FOUR_X - six_t);
    end else begin
      r.rgn = RG_BOT;
    end
    return r;
  endfunction

  // Divide a product by ONE, round to nearest (operand is never negative)
  function automatic logic [SUM_W-1:0] rescale(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] s;
    s = x + HALF_P;
    return SUM_W'(s >> FRAC_BITS);
  endfunction

endpackage

// ----- design/hsl_to_rgb_converter_unit.sv -----
// HSL to RGB pixel converter, four-stage pipeline with stream handshakes.
//
// Usage: pixels enter on the s_axis channel and leave on the m_axis channel,
// one transaction per pixel, in order. A pixel is taken at a rising edge with
// s_axis_tvalid_i and s_axis_tready_o both high and reaches m_axis through the
// stage registers. Throughput is one pixel per clock unless the receiver stalls;
// the three channel ramps each own a multiplier; nothing is shared between pixels.
// Stages: (1) clamp inputs, multiply l*s, pick ramp segments for the three
// hue samples; (2) round l*s, form q, p and q-p; (3) three ramp multiplies;
// (4) round, add p, clamp, select gray, output register.
// Each stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls. A stalled
// output holds its pixel; once all four stages are full s_axis_tready_o
// drops. Reset empties the pipeline; no pixel is lost or repeated.
// tdata of both channels: four 13-bit fields from bit 0 up, upper 4 bits zero.
module hsl_to_rgb_converter_unit
  import hslrgb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // hue[12:0], saturation[25:13], lightness[38:26], alpha_in[51:39]
  input  logic [TDATA_W-1:0] s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // red[12:0], green[25:13], blue[38:26], alpha_out[51:39]
  output logic [TDATA_W-1:0] m_axis_tdata_o
);

  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic en1, en2, en3, en4;

  assign en4 = ~vld4_q | m_axis_tready_i;
  assign en3 = ~vld3_q | en4;
  assign en2 = ~vld2_q | en3;
  assign en1 = ~vld1_q | en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= s_axis_tvalid_i;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
      if (en4) vld4_q <= vld3_q;
    end
  end

  // Stage 1
  logic [VAL_W-1:0]   h_d, s_d, l_d;
  logic [2:0][VAL_W-1:0] t_d;
  ramp_sel_t [2:0]    sel_d;
  logic [PROD_W-1:0]  ls_prod_d;

  always_comb begin
    h_d = sat_one(s_axis_tdata_i[FIELD_W-1:0]);
    s_d = sat_one(s_axis_tdata_i[2*FIELD_W-1:FIELD_W]);
    l_d = sat_one(s_axis_tdata_i[3*FIELD_W-1:2*FIELD_W]);
    ls_prod_d = PROD_W'(l_d) * PROD_W'(s_d);
    // red at h + 1/3, green at h, blue at h - 1/3, wrapped into 0..ONE
    t_d[0] = (h_d + THIRD_V > ONE_V) ? VAL_W'(h_d + THIRD_V - ONE_V) : VAL_W'(h_d + THIRD_V);
    t_d[1] = h_d;
    t_d[2] = (h_d < THIRD_V) ? VAL_W'(h_d + ONE_V - THIRD_V) : VAL_W'(h_d - THIRD_V);
    for (int c = 0; c < 3; c++) sel_d[c] = ramp_select(t_d[c]);
  end

  logic [VAL_W-1:0]   s1_q, l1_q;
  logic [PROD_W-1:0]  ls_prod1_q;
  ramp_sel_t [2:0]    sel1_q;
  logic [FIELD_W-1:0] a1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q       <= s_d;
      l1_q       <= l_d;
      ls_prod1_q <= ls_prod_d;
      sel1_q     <= sel_d;
      a1_q       <= s_axis_tdata_i[4*FIELD_W-1:3*FIELD_W];
    end
  end

  // Stage 2
  logic [VAL_W-1:0] ls, q_d, p_d, dif_d;
  logic [SUM_W-1:0] l2x;

  always_comb begin
    ls  = VAL_W'(rescale(ls_prod1_q));
    l2x = SUM_W'(l1_q) << 1;
    if (l2x < SUM_W'(ONE_V)) q_d = VAL_W'(SUM_W'(l1_q) + SUM_W'(ls));
    else q_d = VAL_W'(SUM_W'(l1_q) + SUM_W'(s1_q) - SUM_W'(ls));
    p_d   = VAL_W'(l2x - SUM_W'(q_d));
    dif_d = q_d - p_d;
  end

  logic [VAL_W-1:0]   q2_q, p2_q, dif2_q, l2_q;
  logic               gray2_q;
  ramp_sel_t [2:0]    sel2_q;
  logic [FIELD_W-1:0] a2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      q2_q    <= q_d;
      p2_q    <= p_d;
      dif2_q  <= dif_d;
      l2_q    <= l1_q;
      gray2_q <= (s1_q == '0);
      sel2_q  <= sel1_q;
      a2_q    <= a1_q;
    end
  end

  // Stage 3: one multiplier per channel
  logic [2:0][PROD_W-1:0] prod_d;

  always_comb begin
    for (int c = 0; c < 3; c++) prod_d[c] = PROD_W'(dif2_q) * PROD_W'(sel2_q[c].fac);
  end

  logic [VAL_W-1:0]       q3_q, p3_q, l3_q;
  logic                   gray3_q;
  logic [2:0][PROD_W-1:0] prod3_q;
  region_e [2:0]          rgn3_q;
  logic [FIELD_W-1:0]     a3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      q3_q    <= q2_q;
      p3_q    <= p2_q;
      l3_q    <= l2_q;
      gray3_q <= gray2_q;
      prod3_q <= prod_d;
      for (int c = 0; c < 3; c++) rgn3_q[c] <= sel2_q[c].rgn;
      a3_q    <= a2_q;
    end
  end

  // Stage 4: round, offset, clamp, gray select
  logic [2:0][SUM_W-1:0]   v;
  logic [2:0][FIELD_W-1:0] ch_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (rgn3_q[c])
        RG_RISE, RG_FALL: v[c] = SUM_W'(p3_q) + rescale(prod3_q[c]);
        RG_TOP:           v[c] = SUM_W'(q3_q);
        default:          v[c] = SUM_W'(p3_q);
      endcase
      if (gray3_q) ch_d[c] = FIELD_W'(l3_q);
      else if (v[c] > SUM_W'(ONE_V)) ch_d[c] = FIELD_W'(ONE_V);
      else ch_d[c] = FIELD_W'(v[c]);
    end
  end

  logic [2:0][FIELD_W-1:0] ch4_q;
  logic [FIELD_W-1:0]      a4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      ch4_q <= ch_d;
      a4_q  <= a3_q;
    end
  end

  assign m_axis_tvalid_o = vld4_q;
  assign m_axis_tdata_o  = TDATA_W'({a4_q, ch4_q[2], ch4_q[1], ch4_q[0]});

endmodule

// ----- verif/hsl_to_rgb_converter_unit_tb.sv -----
// Stream testbench for the HSL to RGB converter: directed corners, random pixels, stalls.
module hsl_to_rgb_converter_unit_tb;
  import hslrgb_pkg::*;

  localparam int PIPE_DEPTH  = 4;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_PIX  = 1750;
  localparam int MAX_REPORTS = 40;

  // Slot positions inside one packed pixel, lowest field first
  localparam int IDX_HUE   = 0;
  localparam int IDX_SAT   = 1;
  localparam int IDX_LIGHT = 2;
  localparam int IDX_RED   = 0;
  localparam int IDX_GREEN = 1;
  localparam int IDX_BLUE  = 2;
  localparam int IDX_ALPHA = 3;

  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
  localparam logic [FIELD_W-1:0] ONE_F     = FIELD_W'(ONE);
  localparam logic [FIELD_W-1:0] THIRD_F   = FIELD_W'(THIRD);
  localparam logic [FIELD_W-1:0] THIRD2_F  = FIELD_W'(2 * THIRD);

  typedef logic [3:0][FIELD_W-1:0] quad_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;

  quad_t rgba_expected_q[$];
  quad_t hsla_sent_q[$];

  int    mismatch_count   = 0;
  int    pixels_sent      = 0;
  int    results_checked  = 0;
  int    gray_pixels      = 0;
  int    overrange_pixels = 0;
  int    input_stalls     = 0;
  int    burst_left       = 0;
  bit    gaps_on          = 1'b1;

  // Receiver-side stall pattern state
  logic        hold_req    = 1'b0;
  logic        hold_seen   = 1'b0;
  int          hold_left   = 0;
  logic [15:0] stall_mask  = '1;
  int          pattern_age = 0;

  string ch_name[4] = '{"red", "green", "blue", "alpha"};

  hsl_to_rgb_converter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", rgba_expected_q.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Color math
  // ---------------------------------------------------------------------------
  function automatic int clip_unit(input logic [FIELD_W-1:0] v);
    return (int'(v) > ONE) ? ONE : int'(v);
  endfunction

  // Drop FRAC_BITS from a double-width product, round half away from zero
  function automatic int round_frac(input int x);
    if (x >= 0) return (x + ONE / 2) >>> FRAC_BITS;
    return -((-x + ONE / 2) >>> FRAC_BITS);
  endfunction

  function automatic int hue_ramp(input int p, input int q, input int t);
    int v;
    if (t < 0) t += ONE;
    if (t > ONE) t -= ONE;
    if (6 * t < ONE) v = p + round_frac((q - p) * (6 * t));
    else if (2 * t < ONE) v = q;
    else if (3 * t < 2 * ONE) v = p + round_frac((q - p) * (4 * ONE - 6 * t));
    else v = p;
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return v;
  endfunction

  function automatic quad_t hsla_to_rgba(input quad_t px);
    int    h, s, l, ls, q, p;
    quad_t rgba;
    h = clip_unit(px[IDX_HUE]);
    s = clip_unit(px[IDX_SAT]);
    l = clip_unit(px[IDX_LIGHT]);
    if (s == 0) begin
      rgba[IDX_RED]   = FIELD_W'(l);
      rgba[IDX_GREEN] = FIELD_W'(l);
      rgba[IDX_BLUE]  = FIELD_W'(l);
    end else begin
      ls = round_frac(l * s);
      q  = (2 * l < ONE) ? (l + ls) : (l + s - ls);
      p  = 2 * l - q;
      rgba[IDX_RED]   = FIELD_W'(hue_ramp(p, q, h + THIRD));
      rgba[IDX_GREEN] = FIELD_W'(hue_ramp(p, q, h));
      rgba[IDX_BLUE]  = FIELD_W'(hue_ramp(p, q, h - THIRD));
    end
    rgba[IDX_ALPHA] = px[IDX_ALPHA];
    return rgba;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [FIELD_W-1:0] h, input logic [FIELD_W-1:0] s,
                            input logic [FIELD_W-1:0] l, input logic [FIELD_W-1:0] a);
    int    gap;
    quad_t px;
    gap = 0;
    if (burst_left == 0) begin
      gap        = gaps_on ? $urandom_range(1, 6) : 0;
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    px = {a, l, s, h};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(px);
    do @(posedge clk_i); while (!s_axis_tready);
    rgba_expected_q.push_back(hsla_to_rgba(px));
    hsla_sent_q.push_back(px);
    pixels_sent++;
    if (clip_unit(s) == 0) gray_pixels++;
    if (h > ONE || s > ONE || l > ONE) overrange_pixels++;
  endtask

  // Stop offering and wait until every converted pixel has come back
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rgba_expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
  endtask

  function automatic logic [FIELD_W-1:0] pick_level();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return FIELD_W'(ONE);
      2:       return FIELD_W'($urandom_range(ONE + 1, FIELD_MAX));
      3:       return FIELD_W'($urandom_range(0, 15));
      4:       return FIELD_W'($urandom_range(ONE - 15, ONE));
      5:       return FIELD_W'($urandom_range(ONE / 2 - 8, ONE / 2 + 8));
      default: return FIELD_W'($urandom_range(0, ONE));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: rotating stall mask, re-rolled when its age counter runs out, plus long holds
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= stall_mask[0];
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask <= '1;
          1:       stall_mask <= 16'($urandom);
          2:       stall_mask <= 16'($urandom) | 16'($urandom);
          default: stall_mask <= 16'($urandom) & 16'($urandom);
        endcase
        pattern_age <= 63;
      end else begin
        stall_mask  <= {stall_mask[0], stall_mask[15:1]};
        pattern_age <= pattern_age - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls++;
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    quad_t got_rgba, want_rgba, src_hsla;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rgba = m_axis_tdata[4*FIELD_W-1:0];
      if (rgba_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, got_rgba);
      end else begin
        want_rgba = rgba_expected_q.pop_front();
        src_hsla  = hsla_sent_q.pop_front();
        results_checked++;
        for (int i = 0; i < 4; i++) begin
          if (got_rgba[i] !== want_rgba[i]) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: %s for h=%0d s=%0d l=%0d a=%0d: expected %0d, actual %0d",
                       $time, ch_name[i], src_hsla[IDX_HUE], src_hsla[IDX_SAT],
                       src_hsla[IDX_LIGHT], src_hsla[IDX_ALPHA], want_rgba[i], got_rgba[i]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_corner_pixels();
    gaps_on = 1'b1;
    send_pixel(0, 0, 0, 0);
    send_pixel(ONE_F, ONE_F, ONE_F, ONE_F);
    send_pixel(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    // gray: no saturation, lightness passes straight through (clipped)
    send_pixel(0, 0, 2048, 1234);
    send_pixel(700, 0, FIELD_MAX, 5);
    // primaries at full saturation, half lightness
    send_pixel(0, ONE_F, 2048, 0);
    send_pixel(THIRD_F, ONE_F, 2048, 0);
    send_pixel(THIRD2_F, ONE_F, 2048, 0);
    // hue samples that wrap past one or below zero
    send_pixel(ONE_F, 3000, 1500, 100);
    send_pixel(10, 3000, 1500, 100);
    send_pixel(5000, 3000, 1500, 100);
    // ramp segment edges
    send_pixel(682, 3000, 1500, 0);
    send_pixel(683, 3000, 1500, 0);
    send_pixel(2047, 3000, 1500, 0);
    send_pixel(2048, 3000, 1500, 0);
    send_pixel(2730, 3000, 1500, 0);
    send_pixel(2731, 3000, 1500, 0);
    // lightness on either side of one half
    send_pixel(300, ONE_F, 2047, 0);
    send_pixel(300, ONE_F, 2048, 0);
    send_pixel(1, 1, 1, 13'h1555);
    send_pixel(13'h0AAA, 13'h1555, 13'h0AAA, 13'h0AAA);
    send_pixel(13'h1555, 13'h0AAA, 13'h1555, 13'h1FFF);
    drain_pipeline();
  endtask

  task automatic test_random_pixels();
    logic [FIELD_W-1:0] h, s, l, a;
    for (int n = 0; n < RANDOM_PIX; n++) begin
      if (n % 300 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      h = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom) : pick_level();
      s = ($urandom_range(0, 9) == 0) ? '0 : pick_level();
      l = pick_level();
      a = FIELD_W'($urandom);
      send_pixel(h, s, l, a);
      if (n == RANDOM_PIX / 2) drain_pipeline();
    end
    drain_pipeline();
  endtask

  // Hold the output long enough that the pipeline fills and input stalls
  task automatic test_output_hold();
    gaps_on  = 1'b0;
    hold_req <= ~hold_req;
    for (int n = 0; n < 40; n++)
      send_pixel(FIELD_W'($urandom_range(0, ONE)), FIELD_W'($urandom_range(1, ONE)),
                 FIELD_W'($urandom_range(0, ONE)), FIELD_W'($urandom));
    drain_pipeline();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_pixels();
    test_output_hold();
    test_random_pixels();
    test_output_hold();
    while (rgba_expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * PIPE_DEPTH) @(posedge clk_i);
    $display("Converted %0d pixels (%0d gray, %0d with inputs above one), checked %0d results",
             pixels_sent, gray_pixels, overrange_pixels, results_checked);
    $display("Input side held off for %0d cycles by output back-pressure", input_stalls);
    if (mismatch_count == 0 && rgba_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
